// File: design/tcm_pkg.sv
// Shared types, constants and helpers of the wall texture column mapper.
package tcm_pkg;

  localparam int ScreenHeight = 1024;
  localparam int HalfScreen   = ScreenHeight / 2;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam int MaxHeightLog2 = 10;
  localparam int FracBits      = 16;
  localparam int DivStepCount  = MaxHeightLog2 + FracBits + 1;
  localparam int DivCntW       = $clog2(DivStepCount);

  localparam logic [1:0] TexNorth = 2'd0;
  localparam logic [1:0] TexSouth = 2'd1;
  localparam logic [1:0] TexEast  = 2'd2;
  localparam logic [1:0] TexWest  = 2'd3;

  localparam logic [2:0] RegNorthWidth = 3'd0;
  localparam logic [2:0] RegNorthHlog  = 3'd1;
  localparam logic [2:0] RegSouthWidth = 3'd2;
  localparam logic [2:0] RegSouthHlog  = 3'd3;
  localparam logic [2:0] RegEastWidth  = 3'd4;
  localparam logic [2:0] RegEastHlog   = 3'd5;
  localparam logic [2:0] RegWestWidth  = 3'd6;
  localparam logic [2:0] RegWestHlog   = 3'd7;

  typedef struct packed {
    logic [10:0] north_width;
    logic [3:0]  north_hlog;
    logic [10:0] south_width;
    logic [3:0]  south_hlog;
    logic [10:0] east_width;
    logic [3:0]  east_hlog;
    logic [10:0] west_width;
    logic [3:0]  west_hlog;
  } tcm_cfg_t;

  typedef struct packed {
    logic        is_step;
    logic [10:0] column_x;
    logic [10:0] start_row;
    logic [10:0] end_row;
    logic [15:0] height;
    logic [1:0]  tex_id;
    logic [9:0]  tex_col;
    logic [3:0]  hlog;
  } tcm_item_t;

  typedef struct packed {
    logic                    start;
    logic [DivStepCount-1:0] dividend;
    logic [15:0]             divisor;
  } tcm_div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic [DivStepCount-1:0] quot;
  } tcm_div_rsp_t;

  function automatic logic [10:0] tex_width(tcm_cfg_t cfg, logic [1:0] id);
    logic [10:0] w;
    case (id)
      TexNorth: w = cfg.north_width;
      TexSouth: w = cfg.south_width;
      TexEast:  w = cfg.east_width;
      default:  w = cfg.west_width;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] tex_hlog(tcm_cfg_t cfg, logic [1:0] id);
    logic [3:0] l;
    case (id)
      TexNorth: l = cfg.north_hlog;
      TexSouth: l = cfg.south_hlog;
      TexEast:  l = cfg.east_hlog;
      default:  l = cfg.west_hlog;
    endcase
    return (l > 4'(MaxHeightLog2)) ? 4'(MaxHeightLog2) : l;
  endfunction

endpackage

// File: design/tcm_in_if.sv
// Input channel of the column mapper: load and step requests.
interface tcm_in_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [10:0]       column_x;
  logic [10:0]       start_row;
  logic [10:0]       end_row;
  logic [15:0]       wall_height;
  logic              hit_side;
  logic signed [1:0] ray_step_x;
  logic signed [1:0] ray_step_y;
  logic [15:0]       wall_frac;

  modport source (
    output valid, cmd, column_x, start_row, end_row, wall_height, hit_side,
           ray_step_x, ray_step_y, wall_frac,
    input  ready
  );

  modport sink (
    input  valid, cmd, column_x, start_row, end_row, wall_height, hit_side,
           ray_step_x, ray_step_y, wall_frac,
    output ready
  );
endinterface

// File: design/tcm_out_if.sv
// Output channel of the column mapper: at most one pixel request per step.
interface tcm_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] screen_x;
  logic [10:0] screen_y;
  logic [1:0]  texture_id;
  logic [9:0]  texel_col;
  logic [9:0]  texel_row;
  logic        last;

  modport source (
    output valid, screen_x, screen_y, texture_id, texel_col, texel_row, last,
    input  ready
  );

  modport sink (
    input  valid, screen_x, screen_y, texture_id, texel_col, texel_row, last,
    output ready
  );
endinterface

// File: design/wall_texture_column_mapper_top.sv
// Top level of the wall texture column mapper: config registers, front, divider, back.
//
// A load request sets up one wall slice; each step request up to its end row then yields
// one pixel request, one per cycle while the output side keeps up. A load holds the back
// end while it is taken from the queue, while the one-bit-per-cycle restoring divider
// forms the row step, while the quotient is registered and handed over, and during the
// start position multiply. The front queue takes up to four requests ahead during that
// time, so steps that follow a load wait only until the load is finished. Loads give no
// pixel.
module wall_texture_column_mapper_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  tcm_in_if.sink      in_if,
  tcm_out_if.source   out_if
);
  import tcm_pkg::*;

  tcm_cfg_t     cfg_q;
  tcm_item_t    head;
  logic         head_valid;
  logic         pop;
  tcm_div_req_t div_req;
  tcm_div_rsp_t div_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.north_width <= 11'd64;
      cfg_q.north_hlog  <= 4'd6;
      cfg_q.south_width <= 11'd64;
      cfg_q.south_hlog  <= 4'd6;
      cfg_q.east_width  <= 11'd64;
      cfg_q.east_hlog   <= 4'd6;
      cfg_q.west_width  <= 11'd64;
      cfg_q.west_hlog   <= 4'd6;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegNorthWidth: cfg_q.north_width <= cfg_data_i;
        RegNorthHlog:  cfg_q.north_hlog  <= cfg_data_i[3:0];
        RegSouthWidth: cfg_q.south_width <= cfg_data_i;
        RegSouthHlog:  cfg_q.south_hlog  <= cfg_data_i[3:0];
        RegEastWidth:  cfg_q.east_width  <= cfg_data_i;
        RegEastHlog:   cfg_q.east_hlog   <= cfg_data_i[3:0];
        RegWestWidth:  cfg_q.west_width  <= cfg_data_i;
        RegWestHlog:   cfg_q.west_hlog   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  tcm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_if        (in_if),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  tcm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tcm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .out_if       (out_if)
  );

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> !div_rsp.busy && $past(div_rsp.busy))
    else $error("divider done without a finished run");

  a_no_pixel_during_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> !(pop && head_valid && head.is_step))
    else $error("step popped while a load is in progress");

endmodule

// File: design/tcm_front.sv
// Front end: accepts requests, picks the texture and column, and queues them.
module tcm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcm_pkg::tcm_cfg_t  cfg_i,
  tcm_in_if.sink             in_if,
  output logic               head_valid_o,
  output tcm_pkg::tcm_item_t head_o,
  input  logic               pop_i
);
  import tcm_pkg::*;

  tcm_item_t            queue_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]   count_q, count_d;

  logic      push;
  logic      sx_pos, sx_neg, sy_pos, mirror;
  logic [1:0]  id;
  logic [10:0] width;
  logic [26:0] col_prod;
  logic [10:0] col_raw;
  tcm_item_t   item;

  assign sx_pos = (in_if.ray_step_x == 2'sb01);
  assign sx_neg = in_if.ray_step_x[1];
  assign sy_pos = (in_if.ray_step_y == 2'sb01);
  assign mirror = in_if.hit_side ? sy_pos : sx_neg;

  always_comb begin
    if (!in_if.hit_side) begin
      id = sx_pos ? TexEast : TexWest;
    end else begin
      id = sy_pos ? TexSouth : TexNorth;
    end
  end

  assign width    = tex_width(cfg_i, id);
  assign col_prod = 27'(in_if.wall_frac) * 27'(width);
  assign col_raw  = col_prod[26:16];

  always_comb begin
    item.is_step   = in_if.cmd;
    item.column_x  = in_if.column_x;
    item.start_row = in_if.start_row;
    item.end_row   = in_if.end_row;
    item.height    = (in_if.wall_height == 16'd0) ? 16'd1 : in_if.wall_height;
    item.tex_id    = id;
    item.tex_col   = mirror ? 10'(width - col_raw - 11'd1) : col_raw[9:0];
    item.hlog      = tex_hlog(cfg_i, id);
  end

  assign in_if.ready  = (count_q != (QueuePtrW+1)'(QueueDepth));
  assign push         = in_if.valid && in_if.ready;
  assign head_valid_o = (count_q != '0);
  assign head_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item;
    end
  end

endmodule

// File: design/tcm_div.sv
// Restoring divider for the row step, one quotient bit per cycle.
module tcm_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcm_pkg::tcm_div_req_t req_i,
  output tcm_pkg::tcm_div_rsp_t rsp_o
);
  import tcm_pkg::*;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DivCntW-1:0]      cnt_q, cnt_d;
  logic [15:0]             rem_q, rem_d;
  logic [DivStepCount-1:0] acc_q, acc_d;
  logic [15:0]             dvs_q, dvs_d;
  logic [16:0]             trial;
  logic                    fits;

  assign trial = {rem_q, acc_q[DivStepCount-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      acc_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
      acc_d = {acc_q[DivStepCount-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivStepCount - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q;

endmodule

// File: design/tcm_back.sv
// Back end: runs column loads through the divider and emits at most one pixel per step.
module tcm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcm_pkg::tcm_cfg_t     cfg_i,
  input  logic                  head_valid_i,
  input  tcm_pkg::tcm_item_t    head_i,
  output logic                  pop_o,
  output tcm_pkg::tcm_div_req_t div_req_o,
  input  tcm_pkg::tcm_div_rsp_t div_rsp_i,
  tcm_out_if.source             out_if
);
  import tcm_pkg::*;

  localparam logic [1:0] StRun = 2'd0;
  localparam logic [1:0] StDiv = 2'd1;
  localparam logic [1:0] StMul = 2'd2;

  logic [1:0]  state_q, state_d;
  logic        active_q, active_d;
  logic [10:0] cur_x_q, cur_x_d;
  logic [10:0] cur_y_q, cur_y_d;
  logic [10:0] last_y_q, last_y_d;
  logic [1:0]  tex_sel_q, tex_sel_d;
  logic [9:0]  tex_col_q, tex_col_d;
  logic [39:0] row_pos_q, row_pos_d;
  logic [DivStepCount-1:0] row_step_q, row_step_d;
  logic [16:0] off_q, off_d;
  logic        out_valid_q, out_valid_d;
  logic        out_load;

  logic [10:0] screen_x_q, screen_y_q;
  logic [1:0]  texture_id_q;
  logic [9:0]  texel_col_q, texel_row_q;
  logic        last_q;

  logic signed [44:0] pos_prod;
  logic [3:0]  hlog_live;
  logic [9:0]  hmask;
  logic [9:0]  row_int;
  logic        is_last;
  logic        out_free;

  assign pos_prod  = $signed(off_q) * $signed({1'b0, row_step_q});
  assign hlog_live = tex_hlog(cfg_i, tex_sel_q);
  assign hmask     = 10'((11'd1 << hlog_live) - 11'd1);
  assign row_int   = row_pos_q[25:16] + 10'(row_pos_q[39] & (|row_pos_q[15:0]));
  assign is_last   = (cur_y_q == last_y_q);
  assign out_free  = !out_valid_q || out_if.ready;

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    last_y_d    = last_y_q;
    tex_sel_d   = tex_sel_q;
    tex_col_d   = tex_col_q;
    row_pos_d   = row_pos_q;
    row_step_d  = row_step_q;
    off_d       = off_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_load    = 1'b0;
    pop_o       = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = DivStepCount'(1) << (5'(head_i.hlog) + 5'(FracBits));
    div_req_o.divisor  = head_i.height;
    case (state_q)
      StRun: begin
        if (head_valid_i) begin
          if (!head_i.is_step) begin
            pop_o           = 1'b1;
            div_req_o.start = 1'b1;
            cur_x_d   = head_i.column_x;
            cur_y_d   = head_i.start_row;
            last_y_d  = head_i.end_row;
            tex_sel_d = head_i.tex_id;
            tex_col_d = head_i.tex_col;
            active_d  = (head_i.start_row <= head_i.end_row);
            off_d     = 17'(head_i.start_row) - 17'(HalfScreen) + 17'(head_i.height[15:1]);
            state_d   = StDiv;
          end else if (!active_q) begin
            pop_o = 1'b1;
          end else if (out_free) begin
            pop_o       = 1'b1;
            out_load    = 1'b1;
            out_valid_d = 1'b1;
            row_pos_d   = row_pos_q + 40'(row_step_q);
            cur_y_d     = cur_y_q + 11'd1;
            if (is_last) begin
              active_d = 1'b0;
            end
          end
        end
      end
      StDiv: begin
        if (div_rsp_i.done) begin
          row_step_d = div_rsp_i.quot;
          state_d    = StMul;
        end
      end
      StMul: begin
        row_pos_d = pos_prod[39:0];
        state_d   = StRun;
      end
      default: begin
        state_d = StRun;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      active_q    <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      last_y_q    <= '0;
      tex_sel_q   <= '0;
      tex_col_q   <= '0;
      row_pos_q   <= '0;
      row_step_q  <= '0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      last_y_q    <= last_y_d;
      tex_sel_q   <= tex_sel_d;
      tex_col_q   <= tex_col_d;
      row_pos_q   <= row_pos_d;
      row_step_q  <= row_step_d;
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      screen_x_q   <= cur_x_q;
      screen_y_q   <= cur_y_q;
      texture_id_q <= tex_sel_q;
      texel_col_q  <= tex_col_q;
      texel_row_q  <= row_int & hmask;
      last_q       <= is_last;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.screen_x   = screen_x_q;
  assign out_if.screen_y   = screen_y_q;
  assign out_if.texture_id = texture_id_q;
  assign out_if.texel_col  = texel_col_q;
  assign out_if.texel_row  = texel_row_q;
  assign out_if.last       = last_q;

endmodule

// File: dv/tb_wall_texture_column_mapper_top.sv
// Testbench of the wall texture column mapper: directed table, random columns, pixel checks.
module tb_wall_texture_column_mapper_top;
  import tcm_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int SettleWait  = 256;
  localparam int HoldCycles  = 300;
  localparam int PhaseItems  = 90;

  typedef enum logic { CmdLoad = 1'b0, CmdStep = 1'b1 } req_cmd_e;

  typedef enum int { CfgRandom, CfgLow, CfgHigh, CfgWild, CfgMixed } tex_plan_e;

  typedef struct packed {
    logic        cmd;
    logic [10:0] column_x;
    logic [10:0] start_row;
    logic [10:0] end_row;
    logic [15:0] wall_height;
    logic        hit_side;
    logic [1:0]  ray_step_x;
    logic [1:0]  ray_step_y;
    logic [15:0] wall_frac;
  } tcm_req_t;

  typedef struct packed {
    logic [10:0] screen_x;
    logic [10:0] screen_y;
    logic [1:0]  texture_id;
    logic [9:0]  texel_col;
    logic [9:0]  texel_row;
    logic        last;
  } pixel_t;

  typedef struct {
    tcm_req_t req;
    bit       typed;
    pixel_t   px;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [10:0] cfg_data;

  tcm_in_if  req_ch ();
  tcm_out_if pix_ch ();

  wall_texture_column_mapper_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (req_ch),
    .out_if     (pix_ch)
  );

  // Texture registers as last written.
  logic [10:0] tex_w  [4];
  logic [3:0]  tex_hl [4];

  // Slice being scanned.
  logic        col_active;
  logic [10:0] col_x;
  logic [10:0] col_y;
  logic [10:0] col_stop;
  logic [1:0]  col_tex;
  logic [9:0]  col_texel;
  logic [39:0] row_acc;
  logic [31:0] row_inc;

  pixel_t pending_pixels [$];
  dir_row_t dir_rows [$];

  int     idle_pct;
  int     stall_pct;
  bit     rx_hold;
  bit     req_typed;
  pixel_t typed_px;
  int     mismatches;
  int     useful_reqs;
  int     load_count;
  int     pixels_seen;
  int     tex_settings;
  int     cycles;

  always #2 clk = ~clk;

  function automatic logic [3:0] sat_hlog(logic [1:0] id);
    return (tex_hl[id] > 4'(MaxHeightLog2)) ? 4'(MaxHeightLog2) : tex_hl[id];
  endfunction

  function automatic bit map_request(tcm_req_t r, output pixel_t px);
    logic [1:0]  id;
    logic [31:0] w;
    logic [31:0] c;
    logic [31:0] hh;
    logic [31:0] h;
    longint      off;
    longint      prod;
    longint      pos;
    longint      whole;
    longint      hmask;
    px = '0;
    if (r.cmd == CmdLoad) begin
      h = (r.wall_height == 16'd0) ? 32'd1 : 32'(r.wall_height);
      if (!r.hit_side) id = (r.ray_step_x == 2'b01) ? TexEast : TexWest;
      else id = (r.ray_step_y == 2'b01) ? TexSouth : TexNorth;
      w = 32'(tex_w[id]);
      c = (32'(r.wall_frac) * w) >> 16;
      if ((!r.hit_side && r.ray_step_x[1]) || (r.hit_side && r.ray_step_y == 2'b01))
        c = w - c - 32'd1;
      hh = 32'd1 << sat_hlog(id);
      col_tex   = id;
      col_texel = c[9:0];
      row_inc   = 32'((64'(hh) << 16) / 64'(h));
      off  = longint'(r.start_row) - longint'(HalfScreen) + longint'(h >> 1);
      prod = off * longint'(row_inc);
      row_acc    = prod[39:0];
      col_x      = r.column_x;
      col_y      = r.start_row;
      col_stop   = r.end_row;
      col_active = (r.start_row <= r.end_row);
      return 1'b0;
    end
    if (!col_active) return 1'b0;
    hmask = (longint'(1) << sat_hlog(col_tex)) - 1;
    pos   = $signed(row_acc);
    whole = (pos / 65536) & hmask;
    px.screen_x   = col_x;
    px.screen_y   = col_y;
    px.texture_id = col_tex;
    px.texel_col  = col_texel;
    px.texel_row  = whole[9:0];
    px.last       = (col_y == col_stop);
    row_acc = row_acc + 40'(row_inc);
    col_y   = col_y + 11'd1;
    if (px.last) col_active = 1'b0;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    tcm_req_t r;
    pixel_t   want;
    pixel_t   got;
    bit       gives;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        r = '{req_ch.cmd, req_ch.column_x, req_ch.start_row, req_ch.end_row,
              req_ch.wall_height, req_ch.hit_side, req_ch.ray_step_x,
              req_ch.ray_step_y, req_ch.wall_frac};
        gives = map_request(r, want);
        if (r.cmd == CmdLoad) load_count++;
        if (r.cmd == CmdLoad || gives) useful_reqs++;
        if (req_typed) pending_pixels.push_back(typed_px);
        else if (gives) pending_pixels.push_back(want);
      end
      if (pix_ch.valid && pix_ch.ready) begin
        got = '{pix_ch.screen_x, pix_ch.screen_y, pix_ch.texture_id,
                pix_ch.texel_col, pix_ch.texel_row, pix_ch.last};
        pixels_seen++;
        if (pending_pixels.size() == 0) begin
          flag_mismatch($sformatf("unexpected pixel x=%0d y=%0d", got.screen_x,
                                  got.screen_y));
        end else begin
          want = pending_pixels.pop_front();
          check_field("screen_x", got.screen_x, want.screen_x);
          check_field("screen_y", got.screen_y, want.screen_y);
          check_field("texture_id", got.texture_id, want.texture_id);
          check_field("texel_col", got.texel_col, want.texel_col);
          check_field("texel_row", got.texel_row, want.texel_row);
          check_field("last", got.last, want.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TIMEOUT after %0d cycles, %0d pixels pending", cycles,
               pending_pixels.size());
      $display("tb_wall_texture_column_mapper_top NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    pix_ch.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
  end

  function automatic tcm_req_t load_req(int x, int first, int stop, int h, int side,
                                        int sx, int sy, int frac);
    return '{CmdLoad, 11'(x), 11'(first), 11'(stop), 16'(h), 1'(side), 2'(sx), 2'(sy),
             16'(frac)};
  endfunction

  function automatic tcm_req_t step_req();
    tcm_req_t r;
    r = load_req($urandom_range(2047), $urandom_range(2047), $urandom_range(2047),
                 $urandom_range(16'hFFFF), $urandom_range(1), $urandom_range(3),
                 $urandom_range(3), $urandom_range(16'hFFFF));
    r.cmd = CmdStep;
    return r;
  endfunction

  task automatic offer(tcm_req_t r, bit typed, pixel_t tpx);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= r.cmd;
    req_ch.column_x    <= r.column_x;
    req_ch.start_row   <= r.start_row;
    req_ch.end_row     <= r.end_row;
    req_ch.wall_height <= r.wall_height;
    req_ch.hit_side    <= r.hit_side;
    req_ch.ray_step_x  <= r.ray_step_x;
    req_ch.ray_step_y  <= r.ray_step_y;
    req_ch.wall_frac   <= r.wall_frac;
    req_typed = typed;
    typed_px  = tpx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx[0]) tex_hl[idx[2:1]] = val[3:0];
    else tex_w[idx[2:1]] = val;
    @(negedge clk);
  endtask

  task automatic program_textures(tex_plan_e plan);
    logic [10:0] val;
    for (int i = RegNorthWidth; i <= RegWestHlog; i++) begin
      if (i % 2 == 0) begin
        case (plan)
          CfgLow:   val = 11'd1;
          CfgHigh:  val = 11'd1024;
          CfgWild:  val = ($urandom_range(1) != 0) ? 11'd0 : 11'($urandom_range(1025, 2047));
          CfgMixed: val = 11'($urandom_range(2047));
          default:  val = 11'($urandom_range(1, 1024));
        endcase
      end else begin
        case (plan)
          CfgLow:   val = 11'd0;
          CfgHigh:  val = 11'(MaxHeightLog2);
          CfgWild:  val = 11'($urandom_range(11, 15));
          CfgMixed: val = 11'($urandom_range(15));
          default:  val = 11'($urandom_range(MaxHeightLog2));
        endcase
      end
      write_reg(3'(i), val);
    end
    cfg_we <= 1'b0;
    tex_settings++;
  endtask

  task automatic run_columns(int n);
    tcm_req_t r;
    int       target;
    int       kind;
    int       len;
    int       first;
    int       h;
    int       nsteps;
    target = useful_reqs + n;
    while (useful_reqs < target) begin
      kind = $urandom_range(99);
      len  = $urandom_range(12);
      case ($urandom_range(9))
        0:       h = 0;
        1, 2, 3,
        4, 5:    h = $urandom_range(1, 64);
        6, 7:    h = $urandom_range(65, 2048);
        default: h = $urandom_range(16'hFFFF);
      endcase
      if (kind < 80) begin
        first = $urandom_range(2047 - len);
        r = load_req($urandom_range(2047), first, first + len, h, $urandom_range(1),
                     $urandom_range(3), $urandom_range(3), $urandom_range(16'hFFFF));
        case ($urandom_range(9))
          0:       nsteps = $urandom_range(len);
          1:       nsteps = len + 1 + $urandom_range(1, 3);
          default: nsteps = len + 1;
        endcase
      end else begin
        r = load_req($urandom_range(2047), $urandom_range(2047), $urandom_range(2047), h,
                     $urandom_range(1), $urandom_range(3), $urandom_range(3),
                     $urandom_range(16'hFFFF));
        nsteps = $urandom_range(16);
      end
      offer(r, 1'b0, '0);
      repeat (nsteps) offer(step_req(), 1'b0, '0);
    end
  endtask

  task automatic run_phase(tex_plan_e plan, int idle, int stall, bit hold, int n);
    offer(load_req(0, 1, 0, 1, 0, 0, 0, 0), 1'b0, '0);
    req_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SettleWait) @(negedge clk);
    program_textures(plan);
    idle_pct  = idle;
    stall_pct = stall;
    if (hold) begin
      fork
        begin
          @(posedge clk);
          rx_hold = 1'b1;
          repeat (HoldCycles) @(posedge clk);
          rx_hold = 1'b0;
        end
      join_none
    end
    run_columns(n);
  endtask

  initial begin
    clk      = 1'b0;
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = RegNorthWidth;
    cfg_data = '0;
    req_ch.valid       = 1'b0;
    req_ch.cmd         = CmdLoad;
    req_ch.column_x    = '0;
    req_ch.start_row   = '0;
    req_ch.end_row     = '0;
    req_ch.wall_height = '0;
    req_ch.hit_side    = 1'b0;
    req_ch.ray_step_x  = '0;
    req_ch.ray_step_y  = '0;
    req_ch.wall_frac   = '0;
    pix_ch.ready       = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    rx_hold   = 1'b0;
    req_typed = 1'b0;
    typed_px  = '0;
    mismatches   = 0;
    useful_reqs  = 0;
    load_count   = 0;
    pixels_seen  = 0;
    tex_settings = 0;
    cycles       = 0;
    for (int i = 0; i < 4; i++) begin
      tex_w[i]  = 11'd64;
      tex_hl[i] = 4'd6;
    end
    col_active = 1'b0;
    col_x      = '0;
    col_y      = '0;
    col_stop   = '0;
    col_tex    = TexNorth;
    col_texel  = '0;
    row_acc    = '0;
    row_inc    = '0;

    dir_rows.push_back('{load_req(5, 512, 513, 64, 1, 3, 3, 0), 1'b0, '0});
    dir_rows.push_back('{step_req(), 1'b1,
                         '{11'd5, 11'd512, TexNorth, 10'd0, 10'd32, 1'b0}});
    dir_rows.push_back('{step_req(), 1'b1,
                         '{11'd5, 11'd513, TexNorth, 10'd0, 10'd33, 1'b1}});
    dir_rows.push_back('{step_req(), 1'b0, '0});
    dir_rows.push_back('{load_req(2047, 0, 0, 0, 0, 1, 0, 65535), 1'b0, '0});
    dir_rows.push_back('{step_req(), 1'b1,
                         '{11'd2047, 11'd0, TexEast, 10'd63, 10'd0, 1'b1}});
    dir_rows.push_back('{load_req(0, 2047, 2047, 65535, 0, 3, 0, 0), 1'b0, '0});
    dir_rows.push_back('{step_req(), 1'b0, '0});
    dir_rows.push_back('{load_req(100, 600, 602, 16, 1, 0, 1, 32768), 1'b0, '0});
    dir_rows.push_back('{step_req(), 1'b0, '0});
    dir_rows.push_back('{load_req(1234, 0, 5, 3, 0, 0, 1, 4660), 1'b0, '0});
    dir_rows.push_back('{step_req(), 1'b0, '0});
    dir_rows.push_back('{step_req(), 1'b0, '0});
    dir_rows.push_back('{load_req(9, 300, 303, 5, 0, 2, 0, 43981), 1'b0, '0});
    dir_rows.push_back('{step_req(), 1'b0, '0});
    dir_rows.push_back('{step_req(), 1'b0, '0});
    dir_rows.push_back('{load_req(11, 50, 40, 100, 1, 1, 3, 7), 1'b0, '0});
    dir_rows.push_back('{step_req(), 1'b0, '0});
    dir_rows.push_back('{load_req(1, 1, 2, 1, 1, 0, 2, 1), 1'b0, '0});
    dir_rows.push_back('{step_req(), 1'b0, '0});
    dir_rows.push_back('{step_req(), 1'b0, '0});

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].px);

    run_phase(CfgRandom, 0, 0, 1'b0, PhaseItems);
    run_phase(CfgLow, 56, 0, 1'b0, PhaseItems);
    run_phase(CfgHigh, 0, 56, 1'b1, PhaseItems);
    run_phase(CfgWild, 23, 23, 1'b0, PhaseItems);
    run_phase(CfgMixed, 0, 0, 1'b1, PhaseItems);

    req_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);

    $display("Ran %0d requests (%0d column loads) over %0d texture settings;",
             useful_reqs, load_count, tex_settings + 1);
    $display("checked %0d pixels under sender gaps, output stalls and a long hold-off.",
             pixels_seen);
    if (mismatches == 0) begin
      $display("tb_wall_texture_column_mapper_top OK");
    end else begin
      $display("tb_wall_texture_column_mapper_top NOT OK");
    end
    $finish;
  end

endmodule
